/* rtl/core/sfe_pkg.sv */
// Package for the stuffed frame encoder: command type, byte constants and
// slot positions shared by the front, the command queue and the back.
// No dependencies.
`default_nettype none

package sfe_pkg;

   localparam logic [7:0] MARK_BYTE   = 8'h2A;
   localparam logic [7:0] ESCAPE_BYTE = 8'h40;
   localparam logic [7:0] CHECK_BIT   = 8'h80;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Output slots of one command, in emission order.
   localparam int NUM_SLOTS     = 6;
   localparam int SLOT_OPEN_MK  = 0;
   localparam int SLOT_CODE     = 1;
   localparam int SLOT_DATA     = 2;
   localparam int SLOT_ESCAPE   = 3;
   localparam int SLOT_CLOSE_MK = 4;
   localparam int SLOT_CHECK    = 5;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      logic [7:0]    frame_code;
      logic [7:0]    data_byte;
      logic [7:0]    checksum;
      slot_mask_type slots;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/core/stuffed_frame_encoder_unit.sv */
// Stuffed frame encoder: byte stuffing with start marker, frame code and a
// checksum of byte sum and length. Top level joining sfe_front, sfe_queue and sfe_back.
// Depends on sfe_pkg.
// An accepted item is written into the command queue, and its output beats leave
// through the registered output stage of the back end.
// One output beat per cycle while the receiver is ready; an item gives zero to
// six output bytes (one or two for payload).
// Input beats are taken every cycle while the command queue has room.
// Reset clears the running sum and length, empties the queue and the output.
`default_nettype none

module stuffed_frame_encoder_unit #(
   parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [7:0] data_byte, [15:8] frame_code
   input  wire logic         req_tlast,   // is_last
   input  wire logic [1:0]   req_tuser,   // [0] is_first, [1] has_data
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // out_byte
   output logic              rsp_tlast,   // end_of_frame
   output logic [0:0]        rsp_tuser    // [0] end_of_run
);
   import sfe_pkg::*;

   cmd_type cmd, head;
   logic    push, pop, empty, full, accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   sfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata[7:0]),
      .frame_code (req_tdata[15:8]),
      .is_first   (req_tuser[0]),
      .is_last    (req_tlast),
      .has_data   (req_tuser[1]),
      .accept     (accept),
      .cmd        (cmd),
      .push       (push)
   );

   sfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   sfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/core/sfe_front.sv */
// Front end of the stuffed frame encoder: accepts input beats, keeps the
// running sum and length, and turns each beat into a slot command.
// Depends on sfe_pkg.
`default_nettype none

module sfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [7:0]      data_byte,
   input  wire logic [7:0]      frame_code,
   input  wire logic            is_first,
   input  wire logic            is_last,
   input  wire logic            has_data,
   input  wire logic            accept,
   output sfe_pkg::cmd_type     cmd,
   output logic                 push
);
   import sfe_pkg::*;

   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_new, count_new;
   logic       escape;

   always_comb begin
      sum_new   = is_first ? 8'h00 : sum_ff;
      count_new = is_first ? 8'h00 : count_ff;
      if (has_data) begin
         sum_new   = sum_new + data_byte;
         count_new = count_new + 8'd1;
      end
      escape = has_data && (data_byte == MARK_BYTE);

      cmd.frame_code             = frame_code;
      cmd.data_byte              = data_byte;
      cmd.checksum               = (sum_new ^ count_new) | CHECK_BIT;
      cmd.slots                  = '0;
      cmd.slots[SLOT_OPEN_MK]    = is_first;
      cmd.slots[SLOT_CODE]       = is_first;
      cmd.slots[SLOT_DATA]       = has_data;
      cmd.slots[SLOT_ESCAPE]     = escape;
      cmd.slots[SLOT_CLOSE_MK]   = is_last;
      cmd.slots[SLOT_CHECK]      = is_last;

      push = accept && (is_first || is_last || has_data);

      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         sum_in   = is_last ? 8'h00 : sum_new;
         count_in = is_last ? 8'h00 : count_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 8'h00;
         count_ff <= 8'h00;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sfe_queue.sv */
// Command queue between the front and the back of the stuffed frame encoder.
// Small register file with read and write pointers. Depends on sfe_pkg.
`default_nettype none

module sfe_queue #(
   parameter int DEPTH = sfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sfe_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output sfe_pkg::cmd_type      head,
   output logic                  empty,
   output logic                  full
);
   import sfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == CNT_W'(DEPTH));
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/sfe_back.sv */
// Back end of the stuffed frame encoder: walks the slots of the head command
// one byte per cycle, while the output is not stalled, into the registered output stage. Depends on sfe_pkg.
`default_nettype none

module sfe_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sfe_pkg::cmd_type head,
   input  wire logic            empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte
   output logic                 rsp_tlast,   // end_of_frame
   output logic [0:0]           rsp_tuser    // [0] end_of_run
);
   import sfe_pkg::*;

   logic          started_ff, started_in;
   slot_mask_type remain_ff, remain_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          eof_ff, eof_in;
   logic          eor_ff, eor_in;

   slot_mask_type remain, pick, rest;
   logic          emit;

   always_comb begin
      remain = started_ff ? remain_ff : head.slots;
      pick   = remain & (~remain + slot_mask_type'(1));
      rest   = remain & ~pick;
      emit   = !empty && (!valid_ff || rsp_tready);
      pop    = emit && (rest == '0);

      started_in = started_ff;
      remain_in  = remain_ff;
      if (emit) begin
         started_in = (rest != '0);
         remain_in  = rest;
      end

      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      eof_in   = eof_ff;
      eor_in   = eor_ff;
      if (emit) begin
         valid_in = 1'b1;
         eof_in   = pick[SLOT_CHECK];
         eor_in   = (rest == '0);
         byte_in  = MARK_BYTE;
         if (pick[SLOT_CODE]) begin
            byte_in = head.frame_code;
         end else if (pick[SLOT_DATA]) begin
            byte_in = head.data_byte;
         end else if (pick[SLOT_ESCAPE]) begin
            byte_in = ESCAPE_BYTE;
         end else if (pick[SLOT_CHECK]) begin
            byte_in = head.checksum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
      remain_ff <= remain_in;
      byte_ff   <= byte_in;
      eof_ff    <= eof_in;
      eor_ff    <= eor_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = byte_ff;
   assign rsp_tlast    = eof_ff;
   assign rsp_tuser[0] = eor_ff;

`ifndef ASSERT_OFF
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && eof_ff |-> eor_ff)
      else $error("checksum beat does not close its run");

   a_started_holds_head: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> !empty && (remain_ff != '0))
      else $error("partly sent command lost from the queue head");
`endif

endmodule

`default_nettype wire

/* tb/stuffed_frame_encoder_checker.sv */
// Checker for the stuffed frame encoder: watches both stream ports, predicts the
// framed byte stream of every accepted input beat and compares output beats in order.
// Depends on sfe_pkg for the marker, escape and checksum constants.
`timescale 1ns / 100ps

module stuffed_frame_encoder_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] frame_code
   input  wire logic        req_tlast,   // is_last
   input  wire logic [1:0]  req_tuser,   // [0] is_first, [1] has_data
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // out_byte
   input  wire logic        rsp_tlast,   // end_of_frame
   input  wire logic [0:0]  rsp_tuser,   // [0] end_of_run
   output int               mismatch_total,
   output int               stream_backlog
);
   import sfe_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       end_of_frame;
   } stream_byte_type;

   stream_byte_type expected_stream[$];
   logic [7:0]      frame_sum = '0;
   logic [7:0]      frame_len = '0;
   int              mismatches = 0;

   task automatic report_mismatch(input string detail);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, detail);
   endtask

   task automatic encode_item(input logic [7:0] data_byte, input logic [7:0] frame_code,
                              input logic is_first, input logic is_last,
                              input logic has_data);
      stream_byte_type burst[6];
      int              count;
      count = 0;
      if (is_first) begin
         frame_sum = '0;
         frame_len = '0;
         burst[count] = '{MARK_BYTE, 1'b0, 1'b0};
         count++;
         burst[count] = '{frame_code, 1'b0, 1'b0};
         count++;
      end
      if (has_data) begin
         frame_sum = frame_sum + data_byte;
         frame_len = frame_len + 8'd1;
         burst[count] = '{data_byte, 1'b0, 1'b0};
         count++;
         if (data_byte == MARK_BYTE) begin
            burst[count] = '{ESCAPE_BYTE, 1'b0, 1'b0};
            count++;
         end
      end
      if (is_last) begin
         burst[count] = '{MARK_BYTE, 1'b0, 1'b0};
         count++;
         burst[count] = '{(frame_sum ^ frame_len) | CHECK_BIT, 1'b0, 1'b1};
         count++;
         frame_sum = '0;
         frame_len = '0;
      end
      for (int i = 0; i < count; i++) begin
         burst[i].end_of_run = (i == count - 1);
         expected_stream.push_back(burst[i]);
      end
   endtask

   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         expected_stream.delete();
         frame_sum = '0;
         frame_len = '0;
      end else begin
         // Output first: a beat leaving at this edge never belongs to one arriving now.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stream.size() == 0) begin
               report_mismatch($sformatf("output beat %02h with nothing expected", rsp_tdata));
            end else begin
               want = expected_stream.pop_front();
               if (rsp_tdata !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_tdata, want.out_byte));
               if (rsp_tuser[0] !== want.end_of_run)
                  report_mismatch($sformatf("end_of_run %b, expected %b (byte %02h)",
                                            rsp_tuser[0], want.end_of_run, want.out_byte));
               if (rsp_tlast !== want.end_of_frame)
                  report_mismatch($sformatf("end_of_frame %b, expected %b (byte %02h)",
                                            rsp_tlast, want.end_of_frame, want.out_byte));
            end
         end
         if (req_tvalid && req_tready)
            encode_item(req_tdata[7:0], req_tdata[15:8], req_tuser[0], req_tlast, req_tuser[1]);
      end
      stream_backlog <= expected_stream.size();
      mismatch_total <= mismatches;
   end

endmodule

/* tb/tb_stuffed_frame_encoder_unit.sv */
// Top of the stuffed frame encoder testbench: clock, reset, input beats and
// output back-pressure, with the verdict. Depends on the encoder RTL, sfe_pkg
// and stuffed_frame_encoder_checker.
`timescale 1ns / 100ps

module tb_stuffed_frame_encoder_unit;
   import sfe_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 70;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   int mismatch_total;
   int stream_backlog;
   int items_sent   = 0;
   int stuck_cycles = 0;
   bit gapless      = 1'b0;
   bit quiet_tail   = 1'b0;
   bit hold_output  = 1'b0;

   stuffed_frame_encoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   stuffed_frame_encoder_checker stream_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .stream_backlog (stream_backlog)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_frame_item(input logic [7:0] data_byte, input logic [7:0] frame_code,
                                  input logic is_first, input logic is_last,
                                  input logic has_data);
      if (!gapless && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {frame_code, data_byte};
      req_tlast  <= is_last;
      req_tuser  <= {has_data, is_first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (is_first || is_last || has_data)
         items_sent++;
   endtask

   function automatic logic [7:0] pick_payload();
      if ($urandom_range(0, 3) == 0)
         return MARK_BYTE;
      return 8'($urandom);
   endfunction

   task automatic send_random_frame(input int payload_len);
      logic       bare_open;
      logic       bare_close;
      logic [7:0] code;
      bare_open  = ($urandom_range(0, 5) == 0);
      bare_close = ($urandom_range(0, 5) == 0);
      code       = 8'($urandom);
      if (bare_open)
         send_frame_item(8'($urandom), code, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < payload_len; i++)
         send_frame_item(pick_payload(), (i == 0) ? code : 8'($urandom),
                         !bare_open && i == 0, !bare_close && i == payload_len - 1, 1'b1);
      if (bare_close)
         send_frame_item(8'($urandom), 8'($urandom), 1'b0, 1'b1, 1'b0);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stream_backlog != 0) @(posedge clock);
   endtask

   initial begin
      int choice;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_tuser  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: field extremes, escaping, ignored beats and out-of-order framing.
      send_frame_item(8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
      send_frame_item(8'h2A, 8'hFF, 1'b1, 1'b0, 1'b1);
      send_frame_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      send_frame_item(8'hFF, 8'h00, 1'b0, 1'b0, 1'b1);
      send_frame_item(8'h2A, 8'h2A, 1'b0, 1'b1, 1'b1);
      send_frame_item(8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0);
      send_frame_item(8'h2B, 8'h00, 1'b0, 1'b0, 1'b1);
      send_frame_item(8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
      send_frame_item(8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
      send_frame_item(8'h11, 8'h3C, 1'b1, 1'b0, 1'b1);
      send_frame_item(8'h22, 8'hC3, 1'b1, 1'b0, 1'b1);
      send_frame_item(8'hFF, 8'h00, 1'b0, 1'b1, 1'b1);
      send_frame_item(8'h2A, 8'h2A, 1'b1, 1'b1, 1'b1);
      send_frame_item(8'h00, 8'h7E, 1'b1, 1'b0, 1'b0);
      send_frame_item(8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
      send_frame_item(8'h80, 8'h01, 1'b1, 1'b1, 1'b1);
      wait_for_drain();

      // The receiver holds off while beats keep coming, so the queue fills up.
      gapless     = 1'b1;
      hold_output = 1'b1;
      repeat (4) send_random_frame(5);
      gapless = 1'b0;

      // A longer frame, so the running sum wraps several times.
      send_random_frame(40);
      wait_for_drain();

      while (items_sent < 180) begin
         quiet_tail = (items_sent >= 150);
         choice = $urandom_range(0, 19);
         if (choice < 2)
            send_frame_item(8'($urandom), 8'($urandom), 1'b1, 1'b1, 1'b0);
         else if (choice < 5)
            send_frame_item(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_random_frame($urandom_range(1, 8));
         if (!quiet_tail && $urandom_range(0, 24) == 0)
            wait_for_drain();
      end

      wait_for_drain();
      repeat (12) @(posedge clock);
      if (mismatch_total == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int pause;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            pause = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
